/* sv/nearest_three_point_select_unit_macros.svh */
// Assertion macros for the nearest three point select unit.
// Included by the RTL files that check their own control logic.
`ifndef NEAREST_THREE_POINT_SELECT_UNIT_MACROS_SVH
`define NEAREST_THREE_POINT_SELECT_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define NTPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define NTPS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define NTPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define NTPS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* sv/ntps_pkg.sv */
// Shared types and constants of the nearest three point select unit.
// No dependencies; used by the top level, the rank list and the result buffer.
`default_nettype none

package ntps_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int unsigned SET_FIELD_W = 6;
  localparam int unsigned PIDX_W      = 4;
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned DIST_W      = 33;
  localparam int unsigned FLOOR_W     = 16;

  // Points per set and number of kept neighbors.
  localparam int unsigned NUM_POINTS = 12;
  localparam int unsigned KEEP       = 3;

  localparam logic [PIDX_W-1:0] LAST_POINT = PIDX_W'(NUM_POINTS - 1);

  // Distance floor after reset, about 0.0001 in Q.24.
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 16'd1678;

  // Request codes.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic [SET_FIELD_W-1:0]    set_index;
    logic [PIDX_W-1:0]         point_index;
    logic signed [COORD_W-1:0] coord_a;
    logic signed [COORD_W-1:0] coord_b;
  } req_t;

  typedef struct packed {
    logic [PIDX_W-1:0] ref_index;
    logic [DIST_W-1:0] distance_sq;
    logic              last;
  } rsp_t;

  // One candidate neighbor: point index and clamped squared distance.
  typedef struct packed {
    logic [PIDX_W-1:0] idx;
    logic [DIST_W-1:0] dsq;
  } cand_t;

  // Control of the rank list from the query sequencer.
  typedef struct packed {
    logic clear;
    logic ins;
  } rank_ctrl_t;

endpackage

`default_nettype wire

/* sv/ntps_rank.sv */
// Running list of the best candidates of one query, sorted by distance.
// Depends on ntps_pkg for the candidate type and the list length.
`default_nettype none

module ntps_rank (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  ntps_pkg::rank_ctrl_t                    ctrl_i,
  input  ntps_pkg::cand_t                         cand_i,
  output ntps_pkg::cand_t [ntps_pkg::KEEP-1:0]    list_o,
  output logic            [ntps_pkg::KEEP-1:0]    list_vld_o
);

  ntps_pkg::cand_t [ntps_pkg::KEEP-1:0] list_q, list_d;
  logic            [ntps_pkg::KEEP-1:0] vld_q, vld_d;
  logic            [ntps_pkg::KEEP-1:0] le;

  // Slots whose distance is not above the new one stay put, so an
  // earlier index wins a tie. The valid slots form a prefix.
  always_comb begin
    for (int k = 0; k < int'(ntps_pkg::KEEP); k++) begin
      le[k] = vld_q[k] && (list_q[k].dsq <= cand_i.dsq);
    end
  end

  // Insert at the first slot that is not kept and shift the rest down.
  always_comb begin
    list_d = list_q;
    vld_d  = vld_q;
    if (ctrl_i.clear) begin
      vld_d = '0;
    end else if (ctrl_i.ins) begin
      if (!le[0]) begin
        list_d[0] = cand_i;
        vld_d[0]  = 1'b1;
      end
      for (int k = 1; k < int'(ntps_pkg::KEEP); k++) begin
        if (!le[k]) begin
          if (le[k-1]) begin
            list_d[k] = cand_i;
            vld_d[k]  = 1'b1;
          end else begin
            list_d[k] = list_q[k-1];
            vld_d[k]  = vld_q[k-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    list_q <= list_d;
  end

  assign list_o     = list_q;
  assign list_vld_o = vld_q;

endmodule

`default_nettype wire

/* sv/ntps_emit.sv */
// Result buffer: holds the kept neighbors of one query and sends them out
// in ascending index order through an output register. Depends on ntps_pkg.
`default_nettype none

module ntps_emit (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     load_i,
  input  ntps_pkg::cand_t [ntps_pkg::KEEP-1:0]    list_i,
  input  wire             [ntps_pkg::KEEP-1:0]    list_vld_i,
  output logic                                    free_o,
  output logic                                    out_valid_o,
  input  wire                                     out_ready_i,
  output ntps_pkg::rsp_t                          out_data_o
);

  localparam int unsigned SEL_W = (ntps_pkg::KEEP > 1) ? $clog2(ntps_pkg::KEEP) : 1;

  ntps_pkg::cand_t [ntps_pkg::KEEP-1:0] buf_q;
  logic            [ntps_pkg::KEEP-1:0] bvld_q;
  logic                                 out_vld_q;
  ntps_pkg::rsp_t                       out_q;

  logic [SEL_W-1:0]            sel;
  logic [ntps_pkg::PIDX_W-1:0] min_idx;
  logic                        found;
  logic                        any_left;
  logic                        only_one;
  logic                        take;

  // Pick the pending slot with the lowest point index.
  always_comb begin
    sel     = '0;
    min_idx = '0;
    found   = 1'b0;
    for (int k = 0; k < int'(ntps_pkg::KEEP); k++) begin
      if (bvld_q[k] && (!found || (buf_q[k].idx < min_idx))) begin
        sel     = SEL_W'(k);
        min_idx = buf_q[k].idx;
        found   = 1'b1;
      end
    end
  end

  assign any_left = |bvld_q;
  assign only_one = $onehot(bvld_q);
  assign take     = any_left && (!out_vld_q || out_ready_i);
  assign free_o   = !any_left;

  // Pending slot valid bits and the output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvld_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (load_i) begin
        bvld_q <= list_vld_i;
      end else if (take) begin
        bvld_q[sel] <= 1'b0;
      end
      if (take) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= list_i;
    end
    if (take) begin
      out_q.ref_index   <= buf_q[sel].idx;
      out_q.distance_sq <= buf_q[sel].dsq;
      out_q.last        <= only_one;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* sv/nearest_three_point_select_unit.sv */
// Nearest three point select unit: point table memory, query sequencer and
// distance pipeline. Depends on ntps_pkg, ntps_rank, ntps_emit and the macros.
//
// The unit stores NUM_SETS sets of twelve 2-D reference points (Q4.12) in one
// synchronous memory and answers a query with the three nearest points of a
// set, as index and squared distance (Q.24, raised to the distance floor),
// sent in ascending index order with last set on the third. A load
// transaction writes one point; a slot index of twelve or more is dropped.
// A query closes the input until its result is handed to the output buffer:
// the memory read port delivers one stored point per cycle, followed by a
// four-stage difference, square, sum and rank pipeline, then the handoff.
// That handoff waits until the previous query's results have all left the
// buffer; loads are taken while results drain. The point table has no reset:
// reading an entry that was never written gives undefined results. The
// distance floor register is to be written through the configuration channel
// only while the unit is idle; the unit itself does not enforce this.
`default_nettype none
`include "nearest_three_point_select_unit_macros.svh"

module nearest_three_point_select_unit #(
  parameter int unsigned NUM_SETS = 64
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  ntps_pkg::req_t                     in_data_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output ntps_pkg::rsp_t                     out_data_o,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire        [ntps_pkg::FLOOR_W-1:0] cfg_data_i
);

  localparam int unsigned DEPTH    = NUM_SETS * ntps_pkg::NUM_POINTS;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned SET_VALS = 1 << ntps_pkg::SET_FIELD_W;
  localparam int unsigned DIFF_W   = ntps_pkg::COORD_W + 1;
  localparam int unsigned SQ_W     = 2 * ntps_pkg::COORD_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // Set field reduced modulo the number of sets, built at elaboration.
  function automatic logic [SET_VALS-1:0][7:0] set_mod_tab(input int unsigned n);
    logic [SET_VALS-1:0][7:0] tab;
    int unsigned              r;
    r = 0;
    for (int i = 0; i < int'(SET_VALS); i++) begin
      tab[i] = 8'(r);
      if (r + 1 == n) begin
        r = 0;
      end else begin
        r = r + 1;
      end
    end
    return tab;
  endfunction

  localparam logic [SET_VALS-1:0][7:0] SET_MOD = set_mod_tab(NUM_SETS);

  // Control and query registers.
  logic [1:0]                        state_q, state_d;
  logic [ntps_pkg::PIDX_W-1:0]       rd_cnt_q, rd_cnt_d;
  logic [ADDR_W-1:0]                 base_q, base_d;
  logic signed [ntps_pkg::COORD_W-1:0] qa_q, qb_q;
  logic [ntps_pkg::FLOOR_W-1:0]      floor_q;

  // Pipeline registers.
  logic                              rd_vld_q, s1_vld_q, s2_vld_q, s3_vld_q;
  logic [ntps_pkg::PIDX_W-1:0]       rd_idx_q, s1_idx_q, s2_idx_q;
  logic [2*ntps_pkg::COORD_W-1:0]    rd_data_q;
  logic signed [DIFF_W-1:0]          diff_a_q, diff_b_q, diff_a_d, diff_b_d;
  logic [SQ_W-1:0]                   sq_a_q, sq_b_q;
  logic signed [2*DIFF_W-1:0]        prod_a, prod_b;
  logic [ntps_pkg::DIST_W-1:0]       sum_d;
  ntps_pkg::cand_t                   cand_q, cand_d;

  // Point table.
  logic [2*ntps_pkg::COORD_W-1:0]    mem [DEPTH];

  logic                              in_acc;
  logic                              is_query;
  logic                              wr_en;
  logic [SET_W-1:0]                  set_mod;
  logic [ADDR_W-1:0]                 set_base;
  logic [ADDR_W-1:0]                 wr_addr;
  logic [ADDR_W-1:0]                 rd_addr;
  logic                              rd_en;
  logic                              pipe_busy;
  logic                              handoff;
  logic                              emit_free;
  ntps_pkg::rank_ctrl_t              rank_ctrl;
  ntps_pkg::cand_t [ntps_pkg::KEEP-1:0] list;
  logic            [ntps_pkg::KEEP-1:0] list_vld;

  // Input side decode.
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign is_query    = (in_data_i.req_type == ntps_pkg::REQ_QUERY);
  assign set_mod     = SET_W'(SET_MOD[in_data_i.set_index]);
  assign set_base    = ADDR_W'(set_mod) * ADDR_W'(ntps_pkg::NUM_POINTS);
  assign wr_addr     = set_base + ADDR_W'(in_data_i.point_index);
  assign wr_en       = in_acc && !is_query &&
                       (in_data_i.point_index <= ntps_pkg::LAST_POINT);
  assign rd_en       = (state_q == ST_RUN);
  assign rd_addr     = base_q + ADDR_W'(rd_cnt_q);
  assign pipe_busy   = rd_vld_q || s1_vld_q || s2_vld_q || s3_vld_q;
  assign handoff     = (state_q == ST_DRAIN) && !pipe_busy && emit_free;

  // Query sequencer: one read per cycle, then wait for the pipeline and
  // the result buffer. The input stays closed while reads are in flight,
  // so a load can never overlap a read of the same entry.
  always_comb begin
    state_d  = state_q;
    rd_cnt_d = rd_cnt_q;
    base_d   = base_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          state_d  = ST_RUN;
          rd_cnt_d = '0;
          base_d   = set_base;
        end
      end
      ST_RUN: begin
        rd_cnt_d = rd_cnt_q + 1'b1;
        if (rd_cnt_q == ntps_pkg::LAST_POINT) begin
          state_d  = ST_DRAIN;
          rd_cnt_d = '0;
        end
      end
      ST_DRAIN: begin
        if (handoff) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_cnt_q <= '0;
      floor_q  <= ntps_pkg::FLOOR_RESET;
      rd_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_cnt_q <= rd_cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        floor_q <= cfg_data_i;
      end
      rd_vld_q <= rd_en;
      s1_vld_q <= rd_vld_q;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // Query point and set base.
  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    if (in_acc && is_query) begin
      qa_q <= in_data_i.coord_a;
      qb_q <= in_data_i.coord_b;
    end
  end

  // Point table: one write port for loads, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_data_i.coord_b, in_data_i.coord_a};
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Distance pipeline arithmetic.
  assign diff_a_d = {qa_q[ntps_pkg::COORD_W-1], qa_q} -
                    {rd_data_q[ntps_pkg::COORD_W-1], rd_data_q[ntps_pkg::COORD_W-1:0]};
  assign diff_b_d = {qb_q[ntps_pkg::COORD_W-1], qb_q} -
                    {rd_data_q[2*ntps_pkg::COORD_W-1],
                     rd_data_q[2*ntps_pkg::COORD_W-1:ntps_pkg::COORD_W]};
  assign prod_a   = diff_a_q * diff_a_q;
  assign prod_b   = diff_b_q * diff_b_q;
  assign sum_d    = {1'b0, sq_a_q} + {1'b0, sq_b_q};

  // Raise the distance to the floor.
  always_comb begin
    cand_d.idx = s2_idx_q;
    if (sum_d < {{(ntps_pkg::DIST_W - ntps_pkg::FLOOR_W){1'b0}}, floor_q}) begin
      cand_d.dsq = {{(ntps_pkg::DIST_W - ntps_pkg::FLOOR_W){1'b0}}, floor_q};
    end else begin
      cand_d.dsq = sum_d;
    end
  end

  // Difference, square and sum stages.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_cnt_q;
    diff_a_q <= diff_a_d;
    diff_b_q <= diff_b_d;
    s1_idx_q <= rd_idx_q;
    sq_a_q   <= prod_a[SQ_W-1:0];
    sq_b_q   <= prod_b[SQ_W-1:0];
    s2_idx_q <= s1_idx_q;
    cand_q   <= cand_d;
  end

  assign rank_ctrl.clear = in_acc && is_query;
  assign rank_ctrl.ins   = s3_vld_q;

  ntps_rank u_rank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (rank_ctrl),
    .cand_i     (cand_q),
    .list_o     (list),
    .list_vld_o (list_vld)
  );

  ntps_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (handoff),
    .list_i      (list),
    .list_vld_i  (list_vld),
    .free_o      (emit_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A new transaction is never taken while the distance pipeline holds points.
  `NTPS_ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni, in_acc && pipe_busy, "input taken while pipeline busy")
  // Every query has at least KEEP points, so the rank list is full at handoff.
  `NTPS_ASSERT(a_full_list, clk_i, rst_ni, handoff |-> (&list_vld), "rank list not full at handoff")
  // The sequencer issues exactly one read per point of the set.
  `NTPS_ASSERT(a_reads_done, clk_i, rst_ni, (state_q == ST_DRAIN) |-> (rd_cnt_q == '0), "read count off at end of reads")
  // The read of the last point is followed by the drain state.
  `NTPS_ASSERT(a_run_end, clk_i, rst_ni, (rd_en && (rd_cnt_q == ntps_pkg::LAST_POINT)) |=> (state_q == ST_DRAIN) && rd_vld_q, "last read not followed by drain")

endmodule

`default_nettype wire
